// ===== design/arm_pkg.sv =====
`default_nettype none
package arm_pkg;

   localparam int MOD_BITS = 30;
   localparam int EXP_BITS = 63;
   localparam int CNT_BITS = $clog2(MOD_BITS);

   localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

   // Control of one serial multiplier: load captures the operands and clears
   // the accumulator, step consumes one multiplier bit.
   typedef struct packed {
      logic load;
      logic step;
   } mm_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SETUP,
      ST_NEXT,
      ST_MUL,
      ST_UPDATE,
      ST_FINAL,
      ST_DONE
   } state_type;

   // Sum of two residues, brought back below the modulus.
   function automatic logic [MOD_BITS-1:0] mod_add(input logic [MOD_BITS-1:0] a,
                                                   input logic [MOD_BITS-1:0] b,
                                                   input logic [MOD_BITS-1:0] m);
      logic [MOD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[MOD_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== design/arm_mulmod.sv =====
`default_nettype none
module arm_mulmod import arm_pkg::*; (
   input  wire logic                clock,
   input  wire mm_ctl_type          ctl,
   input  wire logic [MOD_BITS-1:0] x_val,
   input  wire logic [MOD_BITS-1:0] y_val,
   input  wire logic [MOD_BITS-1:0] modulus,
   output logic      [MOD_BITS-1:0] product
);

   logic [MOD_BITS-1:0] x_ff, x_in;
   logic [MOD_BITS-1:0] y_ff, y_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS+1:0] dbl;
   logic [MOD_BITS+1:0] m1;
   logic [MOD_BITS+1:0] m2;

   // Interleaved multiply and reduce, multiplier bits taken MSB first.
   always_comb begin
      dbl = {1'b0, acc_ff, 1'b0} + (y_ff[MOD_BITS-1] ? {2'b00, x_ff} : '0);
      m1  = {2'b00, modulus};
      m2  = {1'b0, modulus, 1'b0};
      x_in   = x_ff;
      y_in   = y_ff;
      acc_in = acc_ff;
      if (ctl.load) begin
         x_in   = x_val;
         y_in   = y_val;
         acc_in = '0;
      end else if (ctl.step) begin
         y_in = {y_ff[MOD_BITS-2:0], 1'b0};
         if (dbl >= m2) begin
            acc_in = MOD_BITS'(dbl - m2);
         end else if (dbl >= m1) begin
            acc_in = MOD_BITS'(dbl - m1);
         end else begin
            acc_in = dbl[MOD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;

endmodule
`default_nettype wire

// ===== design/affine_recurrence_mod_power.sv =====
`default_nettype none
// Applies x -> A*x + B to a start value n times modulo a programmable modulus,
// by square-and-multiply over the matrix [[A,B],[0,1]], one exponent bit per
// round. A transfer is taken when start is high and busy is low; busy stays
// high until the cycle in which the result is presented, and is low in that
// cycle. The result appears for exactly one cycle with rsp_valid and the
// receiver cannot stall it, so it must be captured then.
// An item passes through a reduction of the inputs, one round of the exponent
// loop per significant bit of step_count (none for a zero count), and a closing
// multiply by x. Each round runs the four bit-serial modular multipliers side
// by side and then updates the matrix registers; reducing the inputs and the
// closing multiply take one pass of the multipliers each.
// A new transfer can be taken in the same cycle as the previous result strobe.
module affine_recurrence_mod_power import arm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [MOD_BITS-1:0] req_mult_coeff,
   input  wire logic [MOD_BITS-1:0] req_add_coeff,
   input  wire logic [EXP_BITS-1:0] req_step_count,
   input  wire logic [MOD_BITS-1:0] req_start_value,
   output logic                     rsp_valid,
   output logic      [MOD_BITS-1:0] rsp_result_value,
   input  wire logic                csr_wr_en,
   input  wire logic [MOD_BITS-1:0] csr_wr_data
);

   state_type state_ff, state_in;

   logic [MOD_BITS-1:0] mod_ff;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [EXP_BITS-1:0] n_ff, n_in;
   logic [MOD_BITS-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic [MOD_BITS-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [MOD_BITS-1:0] xv_ff, xv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MOD_BITS-1:0] rsp_value_ff, rsp_value_in;

   mm_ctl_type          mm_ctl;
   logic [MOD_BITS-1:0] opx [4];
   logic [MOD_BITS-1:0] opy [4];
   logic [MOD_BITS-1:0] prod [4];
   logic                accept;
   logic                last_step;
   logic                tiny_mod;

   assign accept    = start && (state_ff == ST_IDLE);
   assign last_step = (cnt_ff == CNT_BITS'(MOD_BITS - 1));
   // A modulus of zero or one forces a zero result.
   assign tiny_mod  = (mod_ff < MOD_BITS'(2));

   // Modulus: user writes it only while no transfer is in flight; not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MODULUS_RESET;
      end else if (csr_wr_en) begin
         mod_ff <= csr_wr_data;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      xv_in        = xv_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      mm_ctl       = '0;
      for (int i = 0; i < 4; i++) begin
         opx[i] = MOD_BITS'(1);
         opy[i] = '0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            // Reduction of the inputs is a multiply by one.
            opy[0] = req_mult_coeff;
            opy[1] = req_add_coeff;
            opy[2] = req_start_value;
            if (accept) begin
               mm_ctl.load = 1'b1;
               n_in        = req_step_count;
               cnt_in      = '0;
               state_in    = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            mm_ctl.step = 1'b1;
            cnt_in      = cnt_ff + CNT_BITS'(1);
            if (last_step) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            pa_in    = prod[0];
            pb_in    = prod[1];
            xv_in    = prod[2];
            ra_in    = MOD_BITS'(1);
            rb_in    = '0;
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            mm_ctl.load = 1'b1;
            cnt_in      = '0;
            if (n_ff == '0) begin
               // Closing multiply ra * x.
               opx[0]   = xv_ff;
               opy[0]   = ra_ff;
               state_in = ST_FINAL;
            end else begin
               opx[0]   = pb_ff;
               opy[0]   = ra_ff;
               opx[1]   = pa_ff;
               opy[1]   = ra_ff;
               opx[2]   = pb_ff;
               opy[2]   = pa_ff;
               opx[3]   = pa_ff;
               opy[3]   = pa_ff;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mm_ctl.step = 1'b1;
            cnt_in      = cnt_ff + CNT_BITS'(1);
            if (last_step) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (n_ff[0]) begin
               rb_in = mod_add(prod[0], rb_ff, mod_ff);
               ra_in = prod[1];
            end
            pb_in    = mod_add(prod[2], pb_ff, mod_ff);
            pa_in    = prod[3];
            n_in     = n_ff >> 1;
            state_in = ST_NEXT;
         end
         ST_FINAL: begin
            mm_ctl.step = 1'b1;
            cnt_in      = cnt_ff + CNT_BITS'(1);
            if (last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = tiny_mod ? '0 : mod_add(prod[0], rb_ff, mod_ff);
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      n_ff         <= n_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      xv_ff        <= xv_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Four serial multipliers run in lockstep under one counter.
   for (genvar g = 0; g < 4; g++) begin : g_mul
      arm_mulmod u_mul (
         .clock   (clock),
         .ctl     (mm_ctl),
         .x_val   (opx[g]),
         .y_val   (opy[g]),
         .modulus (mod_ff),
         .product (prod[g])
      );
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

   // The result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

   // A taken transfer makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("transfer taken but block not busy");

   // Once the exponent is used up, the closing multiply follows.
   a_exp_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT && n_ff == '0) |=> state_ff == ST_FINAL)
      else $error("exponent exhausted without closing multiply");

   // Every delivered result is a proper residue when the modulus is two or more.
   a_residue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !tiny_mod) |-> rsp_value_ff < mod_ff)
      else $error("result not reduced below modulus");

endmodule
`default_nettype wire
